FILE: src/eprd_pkg.sv
// Package for the external power rail detector.
// Holds the transfer payload types, the register set, the rail state and the fixed levels.
// No dependencies.
package eprd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] ChargeMaxOk     = 16'd25856;
  localparam logic [14:0] ChargeFullScale = 15'd25600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTER_LEVEL   = 3'd0,
    CFG_EXIT_LEVEL    = 3'd1,
    CFG_EXIT_SAMPLES  = 3'd2,
    CFG_SETTLE_MIN_US = 3'd3,
    CFG_CHARGE_DELTA  = 3'd4,
    CFG_FULL_LEVEL    = 3'd5,
    CFG_FULL_CHARGE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_UNKNOWN  = 2'd0,
    SRC_BATTERY  = 2'd1,
    SRC_EXTERNAL = 2'd2
  } power_src_e;

  typedef struct packed {
    logic        read_ok;
    logic [15:0] raw_cell_voltage;
    logic [15:0] raw_charge;
    logic [47:0] time_us;
  } in_t;

  typedef struct packed {
    logic        link_ok;
    logic        seen_ok;
    logic [1:0]  rail_source;
    logic        settling;
    logic        charge_valid;
    logic        charge_in_range;
    logic [15:0] held_voltage;
    logic [15:0] held_charge;
    logic [14:0] clamped_charge;
    logic [31:0] polls;
    logic [31:0] fails;
    logic [47:0] last_good_time;
  } out_t;

  typedef struct packed {
    logic [15:0] enter_level;
    logic [15:0] exit_level;
    logic [3:0]  exit_samples;
    logic [31:0] settle_min_us;
    logic [15:0] charge_delta;
    logic [15:0] full_level;
    logic [15:0] full_charge;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enter_level:   16'd54144,
    exit_level:    16'd53888,
    exit_samples:  4'd3,
    settle_min_us: 32'd15000000,
    charge_delta:  16'd256,
    full_level:    16'd52480,
    full_charge:   16'd23040
  };

  typedef struct packed {
    logic        on_external;
    logic [3:0]  low_run;
    logic        recovering;
    logic [15:0] charge_at_entry;
    logic [47:0] settle_start;
  } rail_t;

endpackage

FILE: src/external_power_rail_detector.sv
// Top level of the external power rail detector: register set, held status and result register.
// Depends on eprd_pkg and eprd_rail.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (eprd_pkg::in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (eprd_pkg::out_t)
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Each poll's status is in the result register in the cycle after its transfer.
// One poll can be accepted in every cycle while the input is not stalled; the single result register sets that figure.
// The input stalls only while a result is held and the output is stalled.
// Reset returns the register set and all state but the result payload register to their initial values.
module external_power_rail_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  eprd_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output eprd_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [eprd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [eprd_pkg::CfgDataW-1:0]       cfg_data_i
);
  import eprd_pkg::*;

  cfg_t        cfg_q;
  rail_t       rail_q, rail_d, rail_next;
  logic        ever_good_q, settling_shown_q;
  logic [15:0] last_voltage_q, last_charge_q;
  logic [47:0] last_time_q;
  logic [31:0] poll_total_q, fail_total_q;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        accept;
  logic        ok;
  logic        in_range;
  logic [15:0] held_charge;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ok          = in_data_i.read_ok;

  eprd_rail u_rail (
    .cfg_i     (cfg_q),
    .rail_i    (rail_q),
    .voltage_i (in_data_i.raw_cell_voltage),
    .charge_i  (in_data_i.raw_charge),
    .time_i    (in_data_i.time_us),
    .rail_o    (rail_next)
  );

  always_comb begin
    rail_d      = ok ? rail_next : rail_q;
    in_range    = ok && (in_data_i.raw_charge <= ChargeMaxOk);
    held_charge = ok ? in_data_i.raw_charge : last_charge_q;

    out_d.link_ok         = ok;
    out_d.seen_ok         = ever_good_q || ok;
    out_d.rail_source     = !ok ? SRC_UNKNOWN :
                            (rail_next.on_external ? SRC_EXTERNAL : SRC_BATTERY);
    out_d.settling        = ok ? rail_next.recovering : settling_shown_q;
    out_d.charge_valid    = in_range && !rail_next.on_external && !rail_next.recovering;
    out_d.charge_in_range = in_range;
    out_d.held_voltage    = ok ? in_data_i.raw_cell_voltage : last_voltage_q;
    out_d.held_charge     = held_charge;
    out_d.clamped_charge  = (held_charge > {1'b0, ChargeFullScale}) ? ChargeFullScale
                                                                    : held_charge[14:0];
    out_d.polls           = poll_total_q + 32'd1;
    out_d.fails           = fail_total_q + {31'd0, !ok};
    out_d.last_good_time  = ok ? in_data_i.time_us : last_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENTER_LEVEL:   cfg_q.enter_level   <= cfg_data_i[15:0];
        CFG_EXIT_LEVEL:    cfg_q.exit_level    <= cfg_data_i[15:0];
        CFG_EXIT_SAMPLES:  cfg_q.exit_samples  <= cfg_data_i[3:0];
        CFG_SETTLE_MIN_US: cfg_q.settle_min_us <= cfg_data_i;
        CFG_CHARGE_DELTA:  cfg_q.charge_delta  <= cfg_data_i[15:0];
        CFG_FULL_LEVEL:    cfg_q.full_level    <= cfg_data_i[15:0];
        CFG_FULL_CHARGE:   cfg_q.full_charge   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q           <= '0;
      ever_good_q      <= 1'b0;
      settling_shown_q <= 1'b0;
      last_voltage_q   <= '0;
      last_charge_q    <= '0;
      last_time_q      <= '0;
      poll_total_q     <= '0;
      fail_total_q     <= '0;
    end else if (accept) begin
      rail_q           <= rail_d;
      ever_good_q      <= out_d.seen_ok;
      settling_shown_q <= out_d.settling;
      last_voltage_q   <= out_d.held_voltage;
      last_charge_q    <= out_d.held_charge;
      last_time_q      <= out_d.last_good_time;
      poll_total_q     <= out_d.polls;
      fail_total_q     <= out_d.fails;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: src/eprd_rail.sv
// Next-state logic of the rail tracker for one good gauge sample.
// Depends on eprd_pkg for the register set, the rail state type and the charge limit.
module eprd_rail (
  input  eprd_pkg::cfg_t  cfg_i,
  input  eprd_pkg::rail_t rail_i,
  input  logic [15:0]     voltage_i,
  input  logic [15:0]     charge_i,
  input  logic [47:0]     time_i,
  output eprd_pkg::rail_t rail_o
);
  import eprd_pkg::*;

  logic [47:0] elapsed;
  logic [15:0] diff;
  logic        moved;
  logic        full;
  logic        settle_done;
  logic [3:0]  run_inc;
  logic        leave;

  always_comb begin
    elapsed     = time_i - rail_i.settle_start;
    diff        = (charge_i >= rail_i.charge_at_entry) ? charge_i - rail_i.charge_at_entry
                                                       : rail_i.charge_at_entry - charge_i;
    moved       = diff >= cfg_i.charge_delta;
    full        = (voltage_i >= cfg_i.full_level) && (charge_i >= cfg_i.full_charge)
                  && (charge_i <= ChargeMaxOk);
    settle_done = (elapsed >= {16'd0, cfg_i.settle_min_us}) && (moved || full);
    run_inc     = rail_i.low_run + 4'd1;
    leave       = (run_inc >= cfg_i.exit_samples) || (run_inc == 4'd0);

    rail_o = rail_i;
    if (voltage_i >= cfg_i.enter_level) begin
      rail_o.on_external     = 1'b1;
      rail_o.low_run         = 4'd0;
      rail_o.recovering      = 1'b0;
      rail_o.charge_at_entry = charge_i;
    end else if (!rail_i.on_external) begin
      if (rail_i.recovering && settle_done) begin
        rail_o.recovering = 1'b0;
      end
    end else if (voltage_i <= cfg_i.exit_level) begin
      if (leave) begin
        rail_o.on_external  = 1'b0;
        rail_o.low_run      = 4'd0;
        rail_o.recovering   = 1'b1;
        rail_o.settle_start = time_i;
      end else begin
        rail_o.low_run = run_inc;
      end
    end else begin
      rail_o.low_run = 4'd0;
    end
  end

endmodule

FILE: src/eprd_checker.sv
// Port-level checks for the external power rail detector, bound to the top level.
// Depends on eprd_pkg and external_power_rail_detector.
module eprd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input eprd_pkg::out_t out_data_o
);
  import eprd_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Every input transfer shows a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted poll produced no result");

  // A failed poll reports no source and no charge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.link_ok |->
      out_data_o.rail_source == SRC_UNKNOWN && !out_data_o.charge_valid
      && !out_data_o.charge_in_range)
    else $error("failed poll reported status");

  // A valid charge needs battery power, no settling, an in-range reading and a good poll seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.charge_valid |->
      out_data_o.rail_source == SRC_BATTERY && !out_data_o.settling
      && out_data_o.charge_in_range && out_data_o.seen_ok)
    else $error("charge marked valid without its conditions");

  // The clamped charge never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.clamped_charge <= ChargeFullScale)
    else $error("clamped charge above full scale");

endmodule

bind external_power_rail_detector eprd_checker u_eprd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
